@@ rtl/core/cpmm_pkg.sv @@
// ============================================================================
// cpmm_pkg: shared types, codes and slope functions of the peak/minimum marker
// Holds the item structs of both channels, the register map, the mark codes
// and the two combinational helpers for the slope flip-flop and the
// end-of-bunch marking.
// ============================================================================
package cpmm_pkg;

    // Field widths
    localparam int CHARGE_BITS    = 10;
    localparam int TIME_BITS      = 10;
    localparam int SMOOTH_BITS    = CHARGE_BITS + 2;
    localparam int MODE_BITS      = 2;
    localparam int STEP_BITS      = 10;
    localparam int MARGIN_BITS    = 12;
    localparam int LOOKBACK_BITS  = 2;
    localparam int CMP_BITS       = ((SMOOTH_BITS > MARGIN_BITS) ? SMOOTH_BITS : MARGIN_BITS) + 1;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 12;

    // Sample window and counters
    localparam int WIN_DEPTH  = 6;
    localparam int HELD_BITS  = 3;
    localparam int COUNT_BITS = 3;
    localparam int COUNT_MAX  = 7;

    // Queue depths
    localparam int FE_QUEUE_DEPTH  = 4;
    localparam int OUT_QUEUE_DEPTH = 2;

    // Smoothing modes (the fourth code behaves as the half-neighbor mode)
    localparam logic [MODE_BITS-1:0] SMOOTH_NONE = 2'd0;
    localparam logic [MODE_BITS-1:0] SMOOTH_SUM  = 2'd1;
    localparam logic [MODE_BITS-1:0] SMOOTH_HALF = 2'd2;

    typedef logic [CHARGE_BITS-1:0] charge_t;
    typedef logic [TIME_BITS-1:0]   tbin_t;
    typedef logic [SMOOTH_BITS-1:0] smooth_t;

    typedef enum logic
    {
        CMD_SAMPLE  = 1'b0,
        CMD_TRAILER = 1'b1
    } command_t;

    typedef enum logic
    {
        KIND_SAMPLE  = 1'b0,
        KIND_TRAILER = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        MARK_NONE = 2'd0,
        MARK_PEAK = 2'd1,
        MARK_MIN  = 2'd2
    } mark_t;

    typedef enum logic [CFG_INDEX_BITS-1:0]
    {
        REG_SMOOTHING_MODE = 3'd0,
        REG_STEP_THRESHOLD = 3'd1,
        REG_FLUCT_MARGIN   = 3'd2,
        REG_PEAK_SUPP      = 3'd3,
        REG_MIN_SUPP       = 3'd4,
        REG_LOOKBACK       = 3'd5
    } reg_index_t;

    typedef enum logic [1:0]
    {
        BK_RUN,
        BK_LAST,
        BK_END,
        BK_FLUSH
    } back_state_t;

    // Channel payloads
    typedef struct packed
    {
        command_t command;
        charge_t  charge;
        tbin_t    sample_time;
        logic     last_in_bunch;
    } in_item_t;

    typedef struct packed
    {
        kind_t   item_kind;
        charge_t out_charge;
        tbin_t   out_time;
        mark_t   mark;
        logic    last_of_run;
    } out_item_t;

    // Configuration registers
    typedef struct packed
    {
        logic [MODE_BITS-1:0]     smoothing_mode;
        logic [STEP_BITS-1:0]     step_threshold;
        logic [MARGIN_BITS-1:0]   fluctuation_margin;
        logic [MARGIN_BITS-1:0]   peak_suppression;
        logic [MARGIN_BITS-1:0]   minimum_suppression;
        logic [LOOKBACK_BITS-1:0] neighbor_lookback;
    } cfg_t;

    // Classified item from the front part, smoothing already done
    typedef struct packed
    {
        command_t              command;
        charge_t               charge;
        tbin_t                 sample_time;
        logic                  last_in_bunch;
        logic [COUNT_BITS-1:0] count;
        smooth_t               q_middle;
        smooth_t               q_last;
    } fe_item_t;

    // Slope flip-flop state
    typedef struct packed
    {
        logic            falling;
        smooth_t [3:0]   hist;
        smooth_t         peak;
        smooth_t         minimum;
        charge_t         prev_raw;
    } slope_t;

    typedef struct packed
    {
        slope_t                slope;
        logic                  mark_en;
        logic [HELD_BITS-1:0]  mark_off;
        mark_t                 mark_val;
    } step_res_t;

    typedef struct packed
    {
        mark_t      first_mark;
        logic       back_en;
        logic [1:0] back_age;
    } end_res_t;

    // One step of the slope flip-flop. mark_off is the distance back from
    // the stepped sample of the sample that takes the mark.
    function automatic step_res_t slope_step(
        cfg_t                  c,
        slope_t                s,
        logic [COUNT_BITS-1:0] idx,
        smooth_t               q,
        charge_t               qu
    );
        step_res_t           r;
        logic                turn;
        logic [CMP_BITS-1:0] qx;
        logic [CMP_BITS-1:0] qux;
        logic [CMP_BITS-1:0] prx;
        logic [CMP_BITS-1:0] stx;
        logic [CMP_BITS-1:0] fmx;
        logic [CMP_BITS-1:0] psx;
        logic [CMP_BITS-1:0] msx;
        logic [CMP_BITS-1:0] h0x;
        logic [CMP_BITS-1:0] pkx;
        logic [CMP_BITS-1:0] mnx;
        qx  = CMP_BITS'(q);
        qux = CMP_BITS'(qu);
        prx = CMP_BITS'(s.prev_raw);
        stx = CMP_BITS'(c.step_threshold);
        fmx = CMP_BITS'(c.fluctuation_margin);
        psx = CMP_BITS'(c.peak_suppression);
        msx = CMP_BITS'(c.minimum_suppression);
        h0x = CMP_BITS'(s.hist[0]);
        pkx = CMP_BITS'(s.peak);
        mnx = CMP_BITS'(s.minimum);
        r          = '0;
        r.slope    = s;
        r.mark_val = MARK_NONE;
        if (!s.falling)
        begin
            turn = ((c.step_threshold != '0) && (qux + stx <= prx)) ||
                   ((c.peak_suppression != '0) ? (qx + psx < pkx) : (qx + fmx < h0x));
            if (turn)
            begin
                r.slope.falling = 1'b1;
                r.slope.minimum = q;
                r.mark_val      = MARK_PEAK;
                r.mark_en       = 1'b1;
                if (c.neighbor_lookback >= 2'd3 && idx > 3'd3 && s.hist[3] > s.hist[2] &&
                    s.hist[3] > s.hist[1] && s.hist[3] > s.hist[0])
                    r.mark_off = 3'd4;
                else if (c.neighbor_lookback >= 2'd2 && idx > 3'd2 &&
                         s.hist[2] > s.hist[1] && s.hist[2] > s.hist[0])
                    r.mark_off = 3'd3;
                else if (c.neighbor_lookback >= 2'd1 && idx > 3'd1 && s.hist[1] > s.hist[0])
                    r.mark_off = 3'd2;
                else if (idx > 3'd0)
                    r.mark_off = 3'd1;
                else
                    r.mark_en = 1'b0;
                r.slope.hist = {4{s.peak}};
            end
            if (q > s.peak)
                r.slope.peak = q;
        end
        else
        begin
            turn = ((c.step_threshold != '0) && (qux >= prx + stx)) ||
                   ((c.minimum_suppression != '0) ? (qx > mnx + msx) : (qx > h0x + fmx));
            if (turn)
            begin
                r.slope.falling = 1'b0;
                r.slope.peak    = q;
                r.mark_val      = MARK_MIN;
                r.mark_en       = 1'b1;
                if (c.neighbor_lookback >= 2'd3 && idx > 3'd3 && s.hist[3] < s.hist[2] &&
                    s.hist[3] < s.hist[1] && s.hist[3] < s.hist[0])
                    r.mark_off = 3'd4;
                else if (c.neighbor_lookback >= 2'd2 && idx > 3'd2 &&
                         s.hist[2] < s.hist[1] && s.hist[2] < s.hist[0])
                    r.mark_off = 3'd3;
                else if (c.neighbor_lookback >= 2'd1 && idx > 3'd1 && s.hist[1] < s.hist[0])
                    r.mark_off = 3'd2;
                else if (idx > 3'd0)
                    r.mark_off = 3'd1;
                else
                    r.mark_en = 1'b0;
                r.slope.hist = {4{s.minimum}};
            end
            if (q < s.minimum)
                r.slope.minimum = q;
        end
        r.slope.hist     = {r.slope.hist[2:0], q};
        r.slope.prev_raw = qu;
        return r;
    endfunction

    // End-of-bunch marks: the newest sample always gets first_mark, and a
    // rising bunch may put its peak up to three samples back.
    function automatic end_res_t end_marks(
        cfg_t                  c,
        slope_t                s,
        logic [COUNT_BITS-1:0] n
    );
        end_res_t r;
        r.first_mark = MARK_MIN;
        r.back_en    = 1'b0;
        r.back_age   = 2'd0;
        if (!s.falling)
        begin
            if (c.neighbor_lookback >= 2'd3 && n > 3'd3 && s.hist[3] > s.hist[2] &&
                s.hist[3] > s.hist[1] && s.hist[3] > s.hist[0])
            begin
                r.back_en  = 1'b1;
                r.back_age = 2'd3;
            end
            else if (c.neighbor_lookback >= 2'd2 && n > 3'd2 &&
                     s.hist[2] > s.hist[1] && s.hist[2] > s.hist[0])
            begin
                r.back_en  = 1'b1;
                r.back_age = 2'd2;
            end
            else if (c.neighbor_lookback >= 2'd1 && n > 3'd1 && s.hist[1] > s.hist[0])
            begin
                r.back_en  = 1'b1;
                r.back_age = 2'd1;
            end
            else
                r.first_mark = MARK_PEAK;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/cpmm_queue.sv @@
// ============================================================================
// cpmm_queue: small register FIFO
// Circular buffer of DEPTH items with registered fill count; full and empty
// come straight from the count register.
// ============================================================================
module cpmm_queue #(
    parameter type ITEM_T = logic,
    parameter int  DEPTH  = 4
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  ITEM_T wdata,
    output logic  full,
    input  logic  pop,
    output ITEM_T rdata,
    output logic  empty
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    ITEM_T               mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

@@ rtl/core/cpmm_front.sv @@
// ============================================================================
// cpmm_front: input stage of the peak/minimum marker
// Takes each transfer, separates trailers from samples, counts the samples
// of the bunch and forms the smoothed charges of the middle and last sample.
// ============================================================================
module cpmm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  cpmm_pkg::cfg_t      cfg,
    input  logic                push,
    input  cpmm_pkg::in_item_t  sample,
    input  logic                q_full,
    output logic                q_push,
    output cpmm_pkg::fe_item_t  q_item
);

    import cpmm_pkg::*;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] count_inc;
    charge_t               prev1_reg, prev1_next;
    charge_t               prev2_reg, prev2_next;
    logic                  accept;
    smooth_t               a_x, b_x, c_x;
    smooth_t               sum_bc, sum_ac, sum_abc;
    smooth_t               q_middle, q_last;

    assign accept    = push && !q_full;
    assign q_push    = accept;
    assign count_inc = (count_reg == COUNT_BITS'(COUNT_MAX)) ? count_reg : count_reg + 1'b1;

    // Three-sample window: a two back, b previous, c current
    assign a_x     = SMOOTH_BITS'(prev2_reg);
    assign b_x     = SMOOTH_BITS'(prev1_reg);
    assign c_x     = SMOOTH_BITS'(sample.charge);
    assign sum_bc  = b_x + c_x;
    assign sum_ac  = a_x + c_x;
    assign sum_abc = sum_ac + b_x;

    // Smoothed charge of the previous sample, now that its successor is here
    always_comb
    begin
        priority if (cfg.smoothing_mode == SMOOTH_NONE)
            q_middle = b_x;
        else if (count_inc == COUNT_BITS'(2))
            q_middle = (cfg.smoothing_mode == SMOOTH_SUM) ? sum_bc + (sum_bc >> 1) : sum_bc;
        else
            q_middle = (cfg.smoothing_mode == SMOOTH_SUM) ? sum_abc : (sum_ac >> 1) + b_x;
    end

    // Smoothed charge of the current sample if it closes the bunch
    always_comb
    begin
        priority if (cfg.smoothing_mode == SMOOTH_NONE)
            q_last = c_x;
        else if (count_inc == COUNT_BITS'(1))
            q_last = (cfg.smoothing_mode == SMOOTH_SUM) ? (c_x << 1) + c_x : c_x << 1;
        else
            q_last = (cfg.smoothing_mode == SMOOTH_SUM) ? sum_bc + (sum_bc >> 1) : sum_bc;
    end

    always_comb
    begin
        q_item.command       = sample.command;
        q_item.charge        = sample.charge;
        q_item.sample_time   = sample.sample_time;
        q_item.last_in_bunch = sample.last_in_bunch;
        q_item.count         = count_inc;
        q_item.q_middle      = q_middle;
        q_item.q_last        = q_last;
    end

    // Bunch tracking; trailers leave it alone
    always_comb
    begin
        count_next = count_reg;
        prev1_next = prev1_reg;
        prev2_next = prev2_reg;
        if (accept && sample.command == CMD_SAMPLE)
        begin
            prev1_next = sample.charge;
            prev2_next = prev1_reg;
            count_next = sample.last_in_bunch ? '0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            prev1_reg <= '0;
            prev2_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            prev1_reg <= prev1_next;
            prev2_reg <= prev2_next;
        end
    end

endmodule

@@ rtl/core/cpmm_back.sv @@
// ============================================================================
// cpmm_back: marking stage of the peak/minimum marker
// Holds the six-sample window and the slope flip-flop, marks turns, releases
// the oldest sample once the window is full and drains the window at the
// end of a bunch.
// ============================================================================
module cpmm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  cpmm_pkg::cfg_t      cfg,
    input  cpmm_pkg::fe_item_t  q_item,
    input  logic                q_empty,
    output logic                q_pop,
    input  logic                o_full,
    output logic                o_push,
    output cpmm_pkg::out_item_t o_item
);

    import cpmm_pkg::*;

    charge_t               win_charge_reg [WIN_DEPTH];
    charge_t               win_charge_next [WIN_DEPTH];
    tbin_t                 win_time_reg [WIN_DEPTH];
    tbin_t                 win_time_next [WIN_DEPTH];
    mark_t                 win_mark_reg [WIN_DEPTH];
    mark_t                 win_mark_next [WIN_DEPTH];
    logic [HELD_BITS-1:0]  held_reg, held_next;
    logic [HELD_BITS-1:0]  held_clip, held_shift, oldest;
    slope_t                slope_reg, slope_next;
    back_state_t           state_reg, state_next;
    logic [COUNT_BITS-1:0] tail_count_reg, tail_count_next;
    smooth_t               tail_q_reg, tail_q_next;
    step_res_t             mid_step, tail_step;
    end_res_t              end_res;

    // Step on the middle sample (base age 1) and on the closing sample (base 0)
    assign mid_step  = slope_step(cfg, slope_reg, q_item.count - COUNT_BITS'(2),
                                  q_item.q_middle, win_charge_reg[0]);
    assign tail_step = slope_step(cfg, slope_reg, tail_count_reg - COUNT_BITS'(1),
                                  tail_q_reg, win_charge_reg[0]);
    assign end_res   = end_marks(cfg, slope_reg, tail_count_reg);

    assign held_clip  = (held_reg > HELD_BITS'(WIN_DEPTH - 1)) ? HELD_BITS'(WIN_DEPTH - 1)
                                                               : held_reg;
    assign held_shift = held_clip + 1'b1;
    assign oldest     = held_reg - 1'b1;

    // Next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        held_next       = held_reg;
        slope_next      = slope_reg;
        tail_count_next = tail_count_reg;
        tail_q_next     = tail_q_reg;
        win_charge_next = win_charge_reg;
        win_time_next   = win_time_reg;
        win_mark_next   = win_mark_reg;
        q_pop           = 1'b0;
        o_push          = 1'b0;
        o_item          = '0;
        unique case (state_reg)
            BK_RUN:
            begin
                if (!q_empty && !o_full)
                begin
                    q_pop = 1'b1;
                    if (q_item.command == CMD_TRAILER)
                    begin
                        // trailer goes straight through
                        o_push             = 1'b1;
                        o_item.item_kind   = KIND_TRAILER;
                        o_item.out_charge  = q_item.charge;
                        o_item.out_time    = q_item.sample_time;
                        o_item.mark        = MARK_NONE;
                        o_item.last_of_run = 1'b0;
                    end
                    else
                    begin
                        // shift the window, newest at age 0
                        for (int a = WIN_DEPTH - 1; a > 0; a--)
                        begin
                            win_charge_next[a] = win_charge_reg[a-1];
                            win_time_next[a]   = win_time_reg[a-1];
                            win_mark_next[a]   = win_mark_reg[a-1];
                        end
                        win_charge_next[0] = q_item.charge;
                        win_time_next[0]   = q_item.sample_time;
                        win_mark_next[0]   = MARK_NONE;
                        held_next          = held_shift;
                        if (q_item.count >= COUNT_BITS'(2))
                        begin
                            slope_next = mid_step.slope;
                            for (int a = 2; a < WIN_DEPTH; a++)
                            begin
                                if (mid_step.mark_en &&
                                    HELD_BITS'(a) == HELD_BITS'(1) + mid_step.mark_off &&
                                    HELD_BITS'(a) < held_shift)
                                    win_mark_next[a] = mid_step.mark_val;
                            end
                        end
                        if (q_item.last_in_bunch)
                        begin
                            tail_count_next = q_item.count;
                            tail_q_next     = q_item.q_last;
                            state_next      = BK_LAST;
                        end
                        else if (held_shift == HELD_BITS'(WIN_DEPTH))
                        begin
                            // window full: release the oldest sample
                            o_push             = 1'b1;
                            o_item.item_kind   = KIND_SAMPLE;
                            o_item.out_charge  = win_charge_next[WIN_DEPTH-1];
                            o_item.out_time    = win_time_next[WIN_DEPTH-1];
                            o_item.mark        = win_mark_next[WIN_DEPTH-1];
                            o_item.last_of_run = 1'b0;
                            held_next          = HELD_BITS'(WIN_DEPTH - 1);
                        end
                    end
                end
            end
            BK_LAST:
            begin
                // step on the closing sample itself
                slope_next = tail_step.slope;
                for (int a = 1; a < WIN_DEPTH - 1; a++)
                begin
                    if (tail_step.mark_en && HELD_BITS'(a) == tail_step.mark_off &&
                        HELD_BITS'(a) < held_reg)
                        win_mark_next[a] = tail_step.mark_val;
                end
                state_next = BK_END;
            end
            BK_END:
            begin
                win_mark_next[0] = end_res.first_mark;
                for (int a = 1; a < 4; a++)
                begin
                    if (end_res.back_en && 2'(a) == end_res.back_age &&
                        HELD_BITS'(a) < held_reg)
                        win_mark_next[a] = MARK_PEAK;
                end
                state_next = BK_FLUSH;
            end
            BK_FLUSH:
            begin
                // drain oldest first, one transfer per cycle while the result queue has room
                if (!o_full)
                begin
                    o_push             = 1'b1;
                    o_item.item_kind   = KIND_SAMPLE;
                    o_item.out_charge  = win_charge_reg[oldest];
                    o_item.out_time    = win_time_reg[oldest];
                    o_item.mark        = win_mark_reg[oldest];
                    o_item.last_of_run = (held_reg == HELD_BITS'(1));
                    held_next          = oldest;
                    if (held_reg == HELD_BITS'(1))
                    begin
                        slope_next = '0;
                        state_next = BK_RUN;
                    end
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_RUN;
            held_reg       <= '0;
            slope_reg      <= '0;
            tail_count_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            held_reg       <= held_next;
            slope_reg      <= slope_next;
            tail_count_reg <= tail_count_next;
        end
    end

    // Window payload and closing charge
    always_ff @(posedge clk)
    begin
        win_charge_reg <= win_charge_next;
        win_time_reg   <= win_time_next;
        win_mark_reg   <= win_mark_next;
        tail_q_reg     <= tail_q_next;
    end

endmodule

@@ rtl/core/charge_peak_minimum_marker.sv @@
// ============================================================================
// charge_peak_minimum_marker: peak and minimum marking of charge samples
// Front stage smooths and classifies, a queue decouples it from the marking
// stage, and a two-entry result queue feeds the output side.
// ============================================================================
// A trailer, or the sample released by a full window, passes the input and result queues
// before it is shown; a closing sample passes the input queue, BK_LAST, BK_END, BK_FLUSH and
// the result queue before its first drained result is shown. Throughput: one item per cycle
// while the input queue has room; it absorbs the drain of up to six held samples at bunch end.
// Reset: asynchronous, active low; clears control registers, queue counts and bunch state.
module charge_peak_minimum_marker #(
    parameter int QUEUE_DEPTH = cpmm_pkg::FE_QUEUE_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [cpmm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [cpmm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  push,
    output logic                                  full,
    input  cpmm_pkg::in_item_t                    sample,
    output logic                                  empty,
    input  logic                                  pop,
    output cpmm_pkg::out_item_t                   result
);

    import cpmm_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      fe_push;
    fe_item_t  fe_wdata;
    logic      fe_pop;
    fe_item_t  fe_rdata;
    logic      fe_empty;
    logic      o_push;
    out_item_t o_item;
    logic      o_full;

    // Configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SMOOTHING_MODE: cfg_next.smoothing_mode      = cfg_data[MODE_BITS-1:0];
                REG_STEP_THRESHOLD: cfg_next.step_threshold      = cfg_data[STEP_BITS-1:0];
                REG_FLUCT_MARGIN:   cfg_next.fluctuation_margin  = cfg_data[MARGIN_BITS-1:0];
                REG_PEAK_SUPP:      cfg_next.peak_suppression    = cfg_data[MARGIN_BITS-1:0];
                REG_MIN_SUPP:       cfg_next.minimum_suppression = cfg_data[MARGIN_BITS-1:0];
                REG_LOOKBACK:       cfg_next.neighbor_lookback   = cfg_data[LOOKBACK_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    // Front stage
    cpmm_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .push   (push),
        .sample (sample),
        .q_full (full),
        .q_push (fe_push),
        .q_item (fe_wdata)
    );

    // Queue between front and marking stage
    cpmm_queue #(
        .ITEM_T (fe_item_t),
        .DEPTH  (QUEUE_DEPTH)
    ) u_fe_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fe_push),
        .wdata (fe_wdata),
        .full  (full),
        .pop   (fe_pop),
        .rdata (fe_rdata),
        .empty (fe_empty)
    );

    // Marking stage
    cpmm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_item  (fe_rdata),
        .q_empty (fe_empty),
        .q_pop   (fe_pop),
        .o_full  (o_full),
        .o_push  (o_push),
        .o_item  (o_item)
    );

    // Result queue
    cpmm_queue #(
        .ITEM_T (out_item_t),
        .DEPTH  (OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (o_push),
        .wdata (o_item),
        .full  (o_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

@@ rtl/core/cpmm_checker.sv @@
// ============================================================================
// cpmm_checker: port-level checks of the peak/minimum marker
// Watches both channels of the top level and is bound to it below.
// ============================================================================
module cpmm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                push,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input cpmm_pkg::out_item_t result
);

    import cpmm_pkg::*;

    // A waiting result holds until it is taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed or vanished while waiting");

    // The input side only fills up through a transfer
    a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without an input transfer");

    // The closing sample of a bunch always carries an end mark
    a_end_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.item_kind == KIND_SAMPLE && result.last_of_run) |->
        (result.mark == MARK_PEAK || result.mark == MARK_MIN))
        else $error("closing sample without end mark");

    // Trailers carry no mark and never close a bunch
    a_trailer_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.item_kind == KIND_TRAILER) |->
        (result.mark == MARK_NONE && !result.last_of_run))
        else $error("trailer with mark or end flag");

endmodule

bind charge_peak_minimum_marker cpmm_checker u_cpmm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for the charge peak/minimum marker
// Drives bunches of charge samples and trailer words through the queue-style
// ports under random idling on both sides. An in-bench predictor tracks the
// smoothing, the slope flip-flop and the end-of-bunch marks, and every result
// transfer is compared field by field with the oldest prediction.
// ============================================================================
module tb;
    import cpmm_pkg::*;

    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 24;
    localparam int TAIL_CYCLES     = 40;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int MAX_REPORTS     = 40;

    // Undocumented smoothing code, behaves as the half-neighbor mode
    localparam logic [MODE_BITS-1:0] SMOOTH_ALIAS = 2'd3;

    typedef struct
    {
        logic       is_cfg;
        reg_index_t reg_idx;
        logic [CFG_DATA_BITS-1:0] reg_val;
        in_item_t   item;
        logic       typed;
        out_item_t  want;
    } stim_row_t;

    // DUT ports
    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      push;
    logic                      full;
    in_item_t                  sample;
    logic                      empty;
    logic                      pop;
    out_item_t                 result;

    // Bench control
    bit        hold_req;
    bit        idle_on;
    logic      row_typed;
    out_item_t row_want;
    int        taken_count;
    int        error_count;
    int        results_checked;
    int        trailers_in;
    int        bunches_closed;
    int        peaks_seen;
    int        minima_seen;

    // Predictor: configuration and bunch state
    cfg_t      model_cfg;
    charge_t   win_charge [WIN_DEPTH];
    tbin_t     win_time [WIN_DEPTH];
    mark_t     win_mark [WIN_DEPTH];
    int        held_cnt;
    smooth_t   slope_hist [4];
    smooth_t   peak_level;
    smooth_t   valley_level;
    logic      falling;
    charge_t   prev_raw;
    logic [COUNT_BITS-1:0] seen_cnt;

    out_item_t produced [$];
    out_item_t expected_results [$];
    stim_row_t stim_table [$];

    charge_peak_minimum_marker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(5_000_000);
        $display("tb failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------------
    function automatic out_item_t make_result(kind_t k, charge_t c, tbin_t t, mark_t m,
                                              logic l);
        out_item_t o;
        o.item_kind   = k;
        o.out_charge  = c;
        o.out_time    = t;
        o.mark        = m;
        o.last_of_run = l;
        return o;
    endfunction

    function automatic in_item_t make_sample(int c, int t, logic l);
        in_item_t it;
        it.command       = CMD_SAMPLE;
        it.charge        = charge_t'(c);
        it.sample_time   = tbin_t'(t);
        it.last_in_bunch = l;
        return it;
    endfunction

    function automatic in_item_t make_trailer(int c, int t, logic l);
        in_item_t it;
        it.command       = CMD_TRAILER;
        it.charge        = charge_t'(c);
        it.sample_time   = tbin_t'(t);
        it.last_in_bunch = l;
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void reset_bunch();
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            win_charge[i] = '0;
            win_time[i]   = '0;
            win_mark[i]   = MARK_NONE;
        end
        for (int i = 0; i < 4; i++)
            slope_hist[i] = '0;
        held_cnt     = 0;
        peak_level   = '0;
        valley_level = '0;
        falling      = 1'b0;
        prev_raw     = '0;
        seen_cnt     = '0;
    endfunction

    // Later marks of a held sample overwrite earlier ones
    function automatic void mark_held(int age, mark_t m);
        if (age < held_cnt && age < WIN_DEPTH)
            win_mark[age] = m;
    endfunction

    // One slope step; base is the age of the sample being stepped
    function automatic void track_slope(int idx, int q, int qu, int base);
        int   h [4];
        int   lb;
        int   st;
        int   fm;
        int   ps;
        int   ms;
        int   pk;
        int   mn;
        int   pr;
        int   off;
        logic turn;
        for (int i = 0; i < 4; i++)
            h[i] = slope_hist[i];
        lb  = model_cfg.neighbor_lookback;
        st  = model_cfg.step_threshold;
        fm  = model_cfg.fluctuation_margin;
        ps  = model_cfg.peak_suppression;
        ms  = model_cfg.minimum_suppression;
        pk  = peak_level;
        mn  = valley_level;
        pr  = prev_raw;
        off = 0;
        if (!falling)
        begin
            turn = (st != 0 && qu + st <= pr) ||
                   ((ps != 0) ? (q + ps < pk) : (q + fm < h[0]));
            if (turn)
            begin
                falling      = 1'b1;
                valley_level = smooth_t'(q);
                if (lb >= 3 && idx > 3 && h[3] > h[2] && h[3] > h[1] && h[3] > h[0])
                    off = 4;
                else if (lb >= 2 && idx > 2 && h[2] > h[1] && h[2] > h[0])
                    off = 3;
                else if (lb >= 1 && idx > 1 && h[1] > h[0])
                    off = 2;
                else if (idx > 0)
                    off = 1;
                if (off > 0)
                    mark_held(base + off, MARK_PEAK);
                for (int i = 0; i < 4; i++)
                    h[i] = pk;
            end
            if (q > pk)
                peak_level = smooth_t'(q);
        end
        else
        begin
            turn = (st != 0 && qu >= pr + st) ||
                   ((ms != 0) ? (q > mn + ms) : (q > h[0] + fm));
            if (turn)
            begin
                falling    = 1'b0;
                peak_level = smooth_t'(q);
                if (lb >= 3 && idx > 3 && h[3] < h[2] && h[3] < h[1] && h[3] < h[0])
                    off = 4;
                else if (lb >= 2 && idx > 2 && h[2] < h[1] && h[2] < h[0])
                    off = 3;
                else if (lb >= 1 && idx > 1 && h[1] < h[0])
                    off = 2;
                else if (idx > 0)
                    off = 1;
                if (off > 0)
                    mark_held(base + off, MARK_MIN);
                for (int i = 0; i < 4; i++)
                    h[i] = mn;
            end
            if (q < mn)
                valley_level = smooth_t'(q);
        end
        slope_hist[3] = smooth_t'(h[2]);
        slope_hist[2] = smooth_t'(h[1]);
        slope_hist[1] = smooth_t'(h[0]);
        slope_hist[0] = smooth_t'(q);
        prev_raw      = charge_t'(qu);
    endfunction

    // Smoothed charge of the sample at age 1
    function automatic int smoothed_middle();
        int a;
        int b;
        int c;
        a = win_charge[2];
        b = win_charge[1];
        c = win_charge[0];
        if (model_cfg.smoothing_mode == SMOOTH_NONE)
            return b;
        if (seen_cnt == 3'd2)
            return (model_cfg.smoothing_mode >= SMOOTH_HALF) ? b + c : (b + c) * 3 / 2;
        if (model_cfg.smoothing_mode >= SMOOTH_HALF)
            return (a + c) / 2 + b;
        return a + b + c;
    endfunction

    // Smoothed charge of the closing sample at age 0
    function automatic int smoothed_final();
        int cur;
        int prv;
        cur = win_charge[0];
        prv = win_charge[1];
        if (model_cfg.smoothing_mode == SMOOTH_NONE)
            return cur;
        if (seen_cnt == 3'd1)
            return (model_cfg.smoothing_mode >= SMOOTH_HALF) ? cur * 2 : cur * 3;
        if (model_cfg.smoothing_mode >= SMOOTH_HALF)
            return cur + prv;
        return (cur + prv) * 3 / 2;
    endfunction

    // End-of-bunch marks; the far peak test compares fourth-back with each of the three newer ones
    function automatic void close_marks();
        int h [4];
        int lb;
        int n;
        for (int i = 0; i < 4; i++)
            h[i] = slope_hist[i];
        lb = model_cfg.neighbor_lookback;
        n  = seen_cnt;
        if (falling)
            mark_held(0, MARK_MIN);
        else if (lb >= 3 && n > 3 && h[3] > h[2] && h[3] > h[1] && h[3] > h[0])
        begin
            mark_held(3, MARK_PEAK);
            mark_held(0, MARK_MIN);
        end
        else if (lb >= 2 && n > 2 && h[2] > h[1] && h[2] > h[0])
        begin
            mark_held(2, MARK_PEAK);
            mark_held(0, MARK_MIN);
        end
        else if (lb >= 1 && n > 1 && h[1] > h[0])
        begin
            mark_held(1, MARK_PEAK);
            mark_held(0, MARK_MIN);
        end
        else
            mark_held(0, MARK_PEAK);
    endfunction

    // Results caused by one accepted item, into produced
    function automatic void predict_item(in_item_t it);
        int age;
        produced.delete();
        if (it.command == CMD_TRAILER)
        begin
            produced.push_back(make_result(KIND_TRAILER, it.charge, it.sample_time,
                                           MARK_NONE, 1'b0));
            return;
        end
        if (held_cnt > WIN_DEPTH - 1)
            held_cnt = WIN_DEPTH - 1;
        for (int i = WIN_DEPTH - 1; i > 0; i--)
        begin
            win_charge[i] = win_charge[i-1];
            win_time[i]   = win_time[i-1];
            win_mark[i]   = win_mark[i-1];
        end
        win_charge[0] = it.charge;
        win_time[0]   = it.sample_time;
        win_mark[0]   = MARK_NONE;
        held_cnt++;
        if (seen_cnt < COUNT_MAX)
            seen_cnt++;
        if (seen_cnt >= 3'd2)
            track_slope(int'(seen_cnt) - 2, smoothed_middle(), win_charge[1], 1);
        if (!it.last_in_bunch)
        begin
            // Full window releases its oldest sample
            if (held_cnt == WIN_DEPTH)
            begin
                produced.push_back(make_result(KIND_SAMPLE, win_charge[WIN_DEPTH-1],
                                               win_time[WIN_DEPTH-1],
                                               win_mark[WIN_DEPTH-1], 1'b0));
                held_cnt = WIN_DEPTH - 1;
            end
            return;
        end
        // Closing sample: final step, end marks, flush oldest first
        track_slope(int'(seen_cnt) - 1, smoothed_final(), win_charge[0], 0);
        close_marks();
        while (held_cnt > 0)
        begin
            age = held_cnt - 1;
            produced.push_back(make_result(KIND_SAMPLE, win_charge[age], win_time[age],
                                           win_mark[age], age == 0));
            held_cnt--;
        end
        reset_bunch();
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: config writes, input transfers, result checks
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin : monitor
        out_item_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SMOOTHING_MODE: model_cfg.smoothing_mode      = cfg_data[MODE_BITS-1:0];
                    REG_STEP_THRESHOLD: model_cfg.step_threshold      = cfg_data[STEP_BITS-1:0];
                    REG_FLUCT_MARGIN:   model_cfg.fluctuation_margin  = cfg_data;
                    REG_PEAK_SUPP:      model_cfg.peak_suppression    = cfg_data;
                    REG_MIN_SUPP:       model_cfg.minimum_suppression = cfg_data;
                    REG_LOOKBACK:       model_cfg.neighbor_lookback   =
                        cfg_data[LOOKBACK_BITS-1:0];
                    default: ;
                endcase
            end
            // Result transfer
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result charge %0d time %0d",
                                              result.out_charge, result.out_time));
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (result.item_kind !== want.item_kind)
                        report_mismatch($sformatf("item_kind got %0d want %0d",
                                                  result.item_kind, want.item_kind));
                    if (result.out_charge !== want.out_charge)
                        report_mismatch($sformatf("out_charge got %0d want %0d",
                                                  result.out_charge, want.out_charge));
                    if (result.out_time !== want.out_time)
                        report_mismatch($sformatf("out_time got %0d want %0d",
                                                  result.out_time, want.out_time));
                    if (result.mark !== want.mark)
                        report_mismatch($sformatf("mark got %0d want %0d at time bin %0d",
                                                  result.mark, want.mark, want.out_time));
                    if (result.last_of_run !== want.last_of_run)
                        report_mismatch($sformatf("last_of_run got %0d want %0d",
                                                  result.last_of_run, want.last_of_run));
                    if (want.mark == MARK_PEAK)
                        peaks_seen++;
                    if (want.mark == MARK_MIN)
                        minima_seen++;
                end
            end
            // Input transfer
            if (push && !full)
            begin
                predict_item(sample);
                if (row_typed)
                    expected_results.push_back(row_want);
                else
                    foreach (produced[i])
                        expected_results.push_back(produced[i]);
                if (sample.command == CMD_TRAILER)
                    trailers_in++;
                else if (sample.last_in_bunch)
                    bunches_closed++;
                taken_count++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, and a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                pop = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                pop = 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge clk);
            end
            else
                pop = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    task automatic send_item(in_item_t it, logic typed, out_item_t want);
        int target;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            push = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        push      = 1'b1;
        sample    = it;
        row_typed = typed;
        row_want  = want;
        target    = taken_count + 1;
        while (taken_count < target)
            @(negedge clk);
    endtask

    task automatic wait_results();
        push = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Idle the block before a register write
    task automatic settle_block();
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [CFG_DATA_BITS-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic load_config(int mode, int step, int fm, int ps, int ms, int lb);
        settle_block();
        write_reg(REG_SMOOTHING_MODE, CFG_DATA_BITS'(mode));
        write_reg(REG_STEP_THRESHOLD, CFG_DATA_BITS'(step));
        write_reg(REG_FLUCT_MARGIN, CFG_DATA_BITS'(fm));
        write_reg(REG_PEAK_SUPP, CFG_DATA_BITS'(ps));
        write_reg(REG_MIN_SUPP, CFG_DATA_BITS'(ms));
        write_reg(REG_LOOKBACK, CFG_DATA_BITS'(lb));
    endtask

    function automatic void add_cfg(reg_index_t idx, int val);
        stim_row_t r;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = CFG_DATA_BITS'(val);
        r.item    = '0;
        r.typed   = 1'b0;
        r.want    = '0;
        stim_table.push_back(r);
    endfunction

    function automatic void add_item(in_item_t it, logic typed, out_item_t want);
        stim_row_t r;
        r.is_cfg  = 1'b0;
        r.reg_idx = REG_SMOOTHING_MODE;
        r.reg_val = '0;
        r.item    = it;
        r.typed   = typed;
        r.want    = want;
        stim_table.push_back(r);
    endfunction

    // Random bunches with shaped charge, some trailers and unclosed bunches
    task automatic play_bunches(int n_items);
        int       sent;
        int       len;
        int       style;
        int       spread;
        int       level;
        int       t;
        logic     open_bunch;
        logic     broken;
        sent       = 0;
        open_bunch = 1'b0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                send_item(make_trailer($urandom, $urandom, $urandom_range(0, 1)), 1'b0, '0);
                sent++;
            end
            else
            begin
                len    = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 16)
                                                     : $urandom_range(1, 8);
                style  = $urandom_range(0, 3);
                spread = (style == 0) ? 20 : (style == 1) ? 150 : 600;
                level  = $urandom_range(0, 1023);
                t      = $urandom_range(0, 1023);
                broken = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < len; k++)
                begin
                    if (style == 3)
                        level = $urandom_range(0, 1023);
                    else
                        level = level + $urandom_range(0, 2 * spread) - spread;
                    if (level < 0)
                        level = 0;
                    if (level > 1023)
                        level = 1023;
                    // Trailer inside an open bunch
                    if ($urandom_range(0, 19) == 0)
                    begin
                        send_item(make_trailer($urandom, $urandom, $urandom_range(0, 1)),
                                  1'b0, '0);
                        sent++;
                    end
                    send_item(make_sample(level, t, (k == len - 1) && !broken), 1'b0, '0);
                    t++;
                    sent++;
                end
                open_bunch = broken;
            end
        end
        if (open_bunch)
            send_item(make_sample($urandom_range(0, 1023), $urandom, 1'b1), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int   mode;
        int   step;
        int   fm;
        int   ps;
        int   ms;
        int   lb;
        logic settled;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        push            = 1'b0;
        sample          = '0;
        row_typed       = 1'b0;
        row_want        = '0;
        hold_req        = 1'b0;
        idle_on         = 1'b1;
        taken_count     = 0;
        error_count     = 0;
        results_checked = 0;
        trailers_in     = 0;
        bunches_closed  = 0;
        peaks_seen      = 0;
        minima_seen     = 0;
        model_cfg       = '0;
        reset_bunch();

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: trailers at the field extremes, single-sample bunches,
        // a bunch split by a trailer, and a rising end with the far lookback
        add_item(make_trailer(1023, 1023, 1'b1), 1'b1,
                 make_result(KIND_TRAILER, 10'd1023, 10'd1023, MARK_NONE, 1'b0));
        add_item(make_trailer(0, 0, 1'b0), 1'b1,
                 make_result(KIND_TRAILER, 10'd0, 10'd0, MARK_NONE, 1'b0));
        add_item(make_sample(1023, 5, 1'b1), 1'b1,
                 make_result(KIND_SAMPLE, 10'd1023, 10'd5, MARK_PEAK, 1'b1));
        add_item(make_sample(0, 0, 1'b1), 1'b1,
                 make_result(KIND_SAMPLE, 10'd0, 10'd0, MARK_PEAK, 1'b1));
        add_item(make_sample(10, 100, 1'b0), 1'b0, '0);
        add_item(make_sample(200, 101, 1'b0), 1'b0, '0);
        add_item(make_sample(800, 102, 1'b0), 1'b0, '0);
        add_item(make_sample(1023, 103, 1'b0), 1'b0, '0);
        add_item(make_sample(600, 104, 1'b0), 1'b0, '0);
        add_item(make_trailer(512, 77, 1'b1), 1'b1,
                 make_result(KIND_TRAILER, 10'd512, 10'd77, MARK_NONE, 1'b0));
        add_item(make_sample(100, 105, 1'b0), 1'b0, '0);
        add_item(make_sample(0, 106, 1'b0), 1'b0, '0);
        add_item(make_sample(50, 107, 1'b0), 1'b0, '0);
        add_item(make_sample(400, 108, 1'b1), 1'b0, '0);
        add_cfg(REG_SMOOTHING_MODE, SMOOTH_ALIAS);
        add_cfg(REG_LOOKBACK, 3);
        add_cfg(REG_FLUCT_MARGIN, 4095);
        add_item(make_sample(100, 200, 1'b0), 1'b0, '0);
        add_item(make_sample(1000, 201, 1'b0), 1'b0, '0);
        add_item(make_sample(300, 202, 1'b0), 1'b0, '0);
        add_item(make_sample(200, 203, 1'b0), 1'b0, '0);
        add_item(make_sample(100, 204, 1'b0), 1'b0, '0);
        add_item(make_sample(50, 205, 1'b1), 1'b0, '0);
        add_cfg(REG_STEP_THRESHOLD, 1);
        add_item(make_sample(1023, 300, 1'b0), 1'b0, '0);
        add_item(make_sample(0, 301, 1'b0), 1'b0, '0);
        add_item(make_sample(1023, 302, 1'b1), 1'b0, '0);

        settled = 1'b1;
        foreach (stim_table[i])
        begin
            if (stim_table[i].is_cfg)
            begin
                if (!settled)
                    settle_block();
                settled = 1'b1;
                write_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
            end
            else
            begin
                settled = 1'b0;
                send_item(stim_table[i].item, stim_table[i].typed, stim_table[i].want);
            end
        end

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                load_config(SMOOTH_HALF, 1023, 4095, 4095, 4095, 3);
            else if (p == 1)
                load_config(SMOOTH_NONE, 0, 0, 0, 0, 0);
            else
            begin
                mode = (p == 2) ? SMOOTH_SUM : (p == 3) ? SMOOTH_ALIAS :
                       (p == 4) ? SMOOTH_HALF : $urandom_range(0, 3);
                step = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
                fm   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095)
                                                   : $urandom_range(0, 100);
                ps   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 300);
                ms   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 300);
                lb   = (p < 6) ? p - 2 : $urandom_range(0, 3);
                load_config(mode, step, fm, ps, ms, lb);
            end
            if (p == PHASES - 1)
                idle_on = 1'b0;
            if (p == 2)
                hold_req = 1'b1;
            if (p == 4)
            begin
                play_bunches(ITEMS_PER_PHASE / 2);
                wait_results();
                play_bunches(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
            end
            else
                play_bunches(ITEMS_PER_PHASE);
        end

        wait_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("run: %0d items taken (%0d trailers, %0d bunches closed), %0d results checked",
                 taken_count, trailers_in, bunches_closed, results_checked);
        $display("run: %0d peaks and %0d minima seen over %0d register settings",
                 peaks_seen, minima_seen, PHASES + 1);
        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/cpmm_pkg.sv
rtl/core/cpmm_queue.sv
rtl/core/cpmm_front.sv
rtl/core/cpmm_back.sv
rtl/core/charge_peak_minimum_marker.sv
rtl/core/cpmm_checker.sv
verif/tb.sv
